// ===== src/flm_pkg.sv =====
// Shared types, sizes and codes for the FIFO lock manager.
package flm_pkg;

	localparam int NUM_LOCKS   = 64;
	localparam int NUM_THREADS = 64;

	localparam int KIND_W   = 2;
	localparam int LOCK_W   = 6;
	localparam int THREAD_W = 6;
	localparam int STATUS_W = 3;

	localparam int LOCK_AW   = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
	localparam int THREAD_AW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

	// The free-slot search works on groups of eight slots.
	localparam int GROUP_W     = 8;
	localparam int GROUP_OFF_W = $clog2(GROUP_W);
	localparam int NUM_GROUPS  = (NUM_LOCKS + GROUP_W - 1) / GROUP_W;
	localparam int GROUP_AW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int PAD_W       = NUM_GROUPS * GROUP_W;

	localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WAIT    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_HELD      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL          = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SELF_DEADLOCK = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [LOCK_W-1:0]   lock_slot;
		logic [THREAD_W-1:0] thread_id;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LOCK_W-1:0]   new_lock;
		logic                blocked;
		logic                wake_valid;
		logic [THREAD_W-1:0] wake_thread;
	} rsp_t;

	// One lock table entry: owner and the two ends of its wait queue.
	typedef struct packed {
		logic [THREAD_W-1:0] owner;
		logic [THREAD_W-1:0] head_thread;
		logic [THREAD_W-1:0] tail_thread;
	} lock_ent_t;

	// One successor link of the per-thread queue chain.
	typedef struct packed {
		logic                succ_valid;
		logic [THREAD_W-1:0] succ_thread;
	} succ_ent_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                accept;
		logic                create;
		logic                del;
		logic                acquire;
		logic                enqueue_first;
		logic                append_link;
		logic                append_clear;
		logic                release_free;
		logic                succ_read;
		logic                handoff;
		logic                res_load;
		logic [STATUS_W-1:0] res_status;
		logic                res_new;
		logic                res_blocked;
		logic                res_wake;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              lock_ok;
		logic              tid_ok;
		logic              held;
		logic              head_valid;
		logic              owner_match;
		logic              any_free;
		logic              hold_valid;
	} sts_t;

endpackage

// ===== src/fifo_lock_manager_top.sv =====
// Top level of the FIFO lock manager: controller plus datapath.
//
// The block keeps a table of mutexes. Each item on the req channel is one
// command: create, delete, wait or release, with a lock slot and a thread.
// Every item produces exactly one item on the rsp channel with a status code,
// the slot a create allocated, a blocked flag for a queued waiter and the
// thread to wake after a release handed the lock over.
// Both channels use valid and stall; an item moves on a rising edge where
// valid is high and stall is low.
// Most commands load the result register in the cycle after acceptance, and
// the next item is taken only once the controller is back in its idle state.
// A wait that appends to a queue needs an extra state, S_LINK2, since the
// successor table has one write port and needs two link writes; a release with
// waiters needs S_HANDOFF, as its successor read follows the lock entry read.
// Reset clears the slot, held and queue flags, so every lock starts free and
// unallocated; the tables need no clearing pass.
// When the receiver stalls, the result waits in the output register and one
// more result can be parked behind it; while that second result waits, no new
// item is accepted.
module fifo_lock_manager_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  flm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output flm_pkg::rsp_t rsp
);
	import flm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	flm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	flm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== src/flm_ram.sv =====
// Generic single write port RAM with one registered read port.
module flm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/flm_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
module flm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  flm_pkg::sts_t sts,
	output flm_pkg::cmd_t cmd
);
	import flm_pkg::*;

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_EXEC    = 2'd1;
	localparam logic [1:0] S_LINK2   = 2'd2;
	localparam logic [1:0] S_HANDOFF = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_stall = (state_q != S_IDLE) || sts.hold_valid;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid && !sts.hold_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.res_load   = 1'b1;
				cmd.res_status = ST_OK;
				state_d        = S_IDLE;
				case (sts.kind)
					KIND_CREATE: begin
						if (sts.any_free) begin
							cmd.create  = 1'b1;
							cmd.res_new = 1'b1;
						end else begin
							cmd.res_status = ST_FULL;
						end
					end
					KIND_DELETE: begin
						if (!sts.lock_ok) begin
							cmd.res_status = ST_INVALID;
						end else begin
							cmd.del = 1'b1;
						end
					end
					KIND_WAIT: begin
						if (!sts.lock_ok || !sts.tid_ok) begin
							cmd.res_status = ST_INVALID;
						end else if (sts.held && sts.owner_match) begin
							cmd.res_status = ST_SELF_DEADLOCK;
						end else if (!sts.held) begin
							cmd.acquire = 1'b1;
						end else if (!sts.head_valid) begin
							cmd.enqueue_first = 1'b1;
							cmd.res_blocked   = 1'b1;
						end else begin
							cmd.append_link = 1'b1;
							cmd.res_load    = 1'b0;
							state_d         = S_LINK2;
						end
					end
					default: begin
						if (!sts.lock_ok) begin
							cmd.res_status = ST_INVALID;
						end else if (!sts.held) begin
							cmd.res_status = ST_NOT_HELD;
						end else if (!sts.head_valid) begin
							cmd.release_free = 1'b1;
						end else begin
							cmd.succ_read = 1'b1;
							cmd.res_load  = 1'b0;
							state_d       = S_HANDOFF;
						end
					end
				endcase
			end
			S_LINK2: begin
				cmd.append_clear = 1'b1;
				cmd.res_load     = 1'b1;
				cmd.res_status   = ST_OK;
				cmd.res_blocked  = 1'b1;
				state_d          = S_IDLE;
			end
			S_HANDOFF: begin
				cmd.handoff    = 1'b1;
				cmd.res_load   = 1'b1;
				cmd.res_status = ST_OK;
				cmd.res_wake   = 1'b1;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/flm_dp.sv =====
// Datapath: lock flags, lock and successor tables, free-slot search, result registers.
module flm_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  flm_pkg::req_t req,
	input  flm_pkg::cmd_t cmd,
	output flm_pkg::sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output flm_pkg::rsp_t rsp
);
	import flm_pkg::*;

	req_t                   item_s1;
	logic [NUM_LOCKS-1:0]   use_q;
	logic [NUM_LOCKS-1:0]   held_q;
	logic [NUM_LOCKS-1:0]   hv_q;

	logic [PAD_W-1:0]       free_pad;
	logic [NUM_GROUPS-1:0]  grp_any_d;
	logic [GROUP_OFF_W-1:0] grp_off_d [NUM_GROUPS];
	logic [NUM_GROUPS-1:0]  grp_any_s1;
	logic [GROUP_OFF_W-1:0] grp_off_s1 [NUM_GROUPS];
	logic                   any_free;
	logic [GROUP_AW-1:0]    pick_grp;
	logic [LOCK_AW-1:0]     create_idx;

	logic [LOCK_AW-1:0]     li_a;
	logic [THREAD_AW-1:0]   tid_a;

	logic [$bits(lock_ent_t)-1:0] lock_rdata;
	lock_ent_t              lock_rd;
	lock_ent_t              lock_wdata;
	logic                   lock_we;

	logic [$bits(succ_ent_t)-1:0] succ_rdata;
	succ_ent_t              succ_rd;
	succ_ent_t              succ_wdata;
	logic [THREAD_AW-1:0]   succ_waddr;
	logic                   succ_we;

	rsp_t                   res_d;
	rsp_t                   out_q;
	logic                   out_valid_q;
	rsp_t                   hold_q;
	logic                   hold_valid_q;
	logic                   out_free;

	assign li_a  = item_s1.lock_slot[LOCK_AW-1:0];
	assign tid_a = item_s1.thread_id[THREAD_AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_s1    <= req;
			grp_any_s1 <= grp_any_d;
			grp_off_s1 <= grp_off_d;
		end
	end

	// First level of the lowest-free-slot search, one priority pick per group.
	always_comb begin
		free_pad = '0;
		free_pad[NUM_LOCKS-1:0] = ~use_q;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_any_d[g] = |free_pad[g*GROUP_W +: GROUP_W];
			grp_off_d[g] = '0;
			for (int b = GROUP_W - 1; b >= 0; b--) begin
				if (free_pad[g*GROUP_W + b]) begin
					grp_off_d[g] = GROUP_OFF_W'(b);
				end
			end
		end
	end

	// Second level: lowest group that still has a free slot.
	always_comb begin
		any_free = 1'b0;
		pick_grp = '0;
		for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				any_free = 1'b1;
				pick_grp = GROUP_AW'(g);
			end
		end
		create_idx = LOCK_AW'(int'(pick_grp) * GROUP_W + int'(grp_off_s1[pick_grp]));
	end

	flm_ram #(
		.WIDTH($bits(lock_ent_t)),
		.DEPTH(NUM_LOCKS)
	) u_lock_ram (
		.clk   (clk),
		.we    (lock_we),
		.waddr (li_a),
		.wdata (lock_wdata),
		.re    (cmd.accept),
		.raddr (req.lock_slot[LOCK_AW-1:0]),
		.rdata (lock_rdata)
	);

	assign lock_rd = lock_ent_t'(lock_rdata);

	flm_ram #(
		.WIDTH($bits(succ_ent_t)),
		.DEPTH(NUM_THREADS)
	) u_succ_ram (
		.clk   (clk),
		.we    (succ_we),
		.waddr (succ_waddr),
		.wdata (succ_wdata),
		.re    (cmd.succ_read),
		.raddr (lock_rd.head_thread[THREAD_AW-1:0]),
		.rdata (succ_rdata)
	);

	assign succ_rd = succ_ent_t'(succ_rdata);

	// Table writes; at most one command is active in a cycle.
	always_comb begin
		lock_we    = cmd.acquire | cmd.enqueue_first | cmd.append_link | cmd.handoff;
		lock_wdata = lock_rd;
		if (cmd.acquire) begin
			lock_wdata.owner = item_s1.thread_id;
		end
		if (cmd.enqueue_first) begin
			lock_wdata.head_thread = item_s1.thread_id;
			lock_wdata.tail_thread = item_s1.thread_id;
		end
		if (cmd.append_link) begin
			lock_wdata.tail_thread = item_s1.thread_id;
		end
		if (cmd.handoff) begin
			lock_wdata.owner = lock_rd.head_thread;
			if (succ_rd.succ_valid) begin
				lock_wdata.head_thread = succ_rd.succ_thread;
			end
		end

		succ_we    = cmd.enqueue_first | cmd.append_link | cmd.append_clear;
		succ_waddr = tid_a;
		succ_wdata = '0;
		if (cmd.append_link) begin
			// Link the old tail to the new waiter.
			succ_waddr             = lock_rd.tail_thread[THREAD_AW-1:0];
			succ_wdata.succ_valid  = 1'b1;
			succ_wdata.succ_thread = item_s1.thread_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_q  <= '0;
			held_q <= '0;
			hv_q   <= '0;
		end else begin
			if (cmd.create) begin
				use_q[create_idx]  <= 1'b1;
				held_q[create_idx] <= 1'b0;
				hv_q[create_idx]   <= 1'b0;
			end
			if (cmd.del) begin
				use_q[li_a]  <= 1'b0;
				held_q[li_a] <= 1'b0;
				hv_q[li_a]   <= 1'b0;
			end
			if (cmd.acquire) begin
				held_q[li_a] <= 1'b1;
				hv_q[li_a]   <= 1'b0;
			end
			if (cmd.enqueue_first) begin
				hv_q[li_a] <= 1'b1;
			end
			if (cmd.release_free) begin
				held_q[li_a] <= 1'b0;
			end
			if (cmd.handoff && !succ_rd.succ_valid) begin
				hv_q[li_a] <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.kind        = item_s1.kind;
		sts.lock_ok     = (32'(item_s1.lock_slot) < NUM_LOCKS) && use_q[li_a];
		sts.tid_ok      = (32'(item_s1.thread_id) < NUM_THREADS);
		sts.held        = held_q[li_a];
		sts.head_valid  = hv_q[li_a];
		sts.owner_match = (lock_rd.owner == item_s1.thread_id);
		sts.any_free    = any_free;
		sts.hold_valid  = hold_valid_q;
	end

	always_comb begin
		res_d.status      = cmd.res_status;
		res_d.new_lock    = cmd.res_new ? LOCK_W'(create_idx) : '0;
		res_d.blocked     = cmd.res_blocked;
		res_d.wake_valid  = cmd.res_wake;
		res_d.wake_thread = cmd.res_wake ? lock_rd.head_thread : '0;
	end

	// Output register with one holding slot behind it.
	assign out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (hold_valid_q) begin
				if (out_free) begin
					out_valid_q  <= 1'b1;
					hold_valid_q <= 1'b0;
				end
			end else if (cmd.res_load) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
				end else begin
					hold_valid_q <= 1'b1;
				end
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hold_valid_q) begin
			if (out_free) begin
				out_q <= hold_q;
			end
		end else if (cmd.res_load) begin
			if (out_free) begin
				out_q <= res_d;
			end else begin
				hold_q <= res_d;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
